FILE: src/lec_pkg.sv
package lec_pkg;

   localparam int ENERGY_W = 32;
   localparam int LOG_W    = 24;
   localparam int SIN_W    = 15;
   localparam int COS_W    = 16;
   localparam int COEF_W   = 25;
   localparam int CIDX_W   = 6;

   localparam int NUM_COEFFS = 20;

   localparam int LOG_FRAC_BITS = 20;
   localparam int NORM_STEPS    = 5;
   localparam int SIN_FRAC      = 14;
   localparam int TERM_ROUND    = 8192;

   localparam logic [29:0] LOG10_2_Q30        = 30'd323228497;
   localparam logic signed [55:0] LOG_ROUND   = 56'sd8589934592;

   localparam longint SIN_C1 = 64'sd1686629713;
   localparam longint SIN_C3 = -64'sd693598668;
   localparam longint SIN_C5 = 64'sd85569306;
   localparam longint SIN_C7 = -64'sd5026996;
   localparam longint SIN_C9 = 64'sd172272;

   localparam logic signed [31:0] COEF_MAX = 32'sd16777215;
   localparam logic signed [31:0] COEF_MIN = -32'sd16777216;

   typedef enum logic [2:0] {
      LOG_IDLE,
      LOG_NORM,
      LOG_SQUARE,
      LOG_SCALE,
      LOG_DONE
   } log_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_WAIT,
      SEQ_WRITE
   } seq_state_type;

   typedef struct packed {
      logic frame_start;
      logic next_coeff;
      logic issue;
      logic first;
      logic last;
   } mac_ctrl_type;

   // sin(pi/2 * u/N) in Q1.14 from the Q30 angle, odd Taylor series to degree 9
   function automatic logic [SIN_W-1:0] sin_quarter(input longint angle);
      longint t2;
      longint p;
      longint s;
      t2 = (angle * angle) >>> 30;
      p = SIN_C9;
      p = SIN_C7 + ((p * t2) >>> 30);
      p = SIN_C5 + ((p * t2) >>> 30);
      p = SIN_C3 + ((p * t2) >>> 30);
      p = SIN_C1 + ((p * t2) >>> 30);
      s = (p * angle) >>> 30;
      s = (s + 64'sd32768) >>> 16;
      if (s < 0) s = 0;
      if (s > 16384) s = 16384;
      return SIN_W'(s);
   endfunction

endpackage

FILE: src/lec_log_unit.sv
module lec_log_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [lec_pkg::ENERGY_W-1:0]         energy,
   output logic                                 idle,
   output logic                                 done,
   output logic signed [lec_pkg::LOG_W-1:0]     log_value
);

   localparam int CNT_W = $clog2(lec_pkg::LOG_FRAC_BITS);

   lec_pkg::log_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [31:0]       x_ff;
   logic [4:0]        zc_ff;
   logic [30:0]       y_ff;
   logic [lec_pkg::LOG_FRAC_BITS-1:0] frac_ff;
   logic signed [55:0] prod_ff;

   logic [31:0]       norm_x;
   logic [4:0]        norm_z;
   logic [61:0]       square;
   logic [31:0]       sq_top;
   logic [4:0]        msb_pos;
   logic signed [5:0] exp_off;
   logic signed [25:0] log2_val;
   logic signed [55:0] rnd_sum;

   // one binary-search step of the leading-one normalization per cycle
   always_comb begin
      norm_x = x_ff;
      norm_z = zc_ff;
      case (cnt_ff)
         CNT_W'(0): if (x_ff[31:16] == '0) begin
            norm_x = {x_ff[15:0], 16'h0};
            norm_z = zc_ff + 5'd16;
         end
         CNT_W'(1): if (x_ff[31:24] == '0) begin
            norm_x = {x_ff[23:0], 8'h0};
            norm_z = zc_ff + 5'd8;
         end
         CNT_W'(2): if (x_ff[31:28] == '0) begin
            norm_x = {x_ff[27:0], 4'h0};
            norm_z = zc_ff + 5'd4;
         end
         CNT_W'(3): if (x_ff[31:30] == '0) begin
            norm_x = {x_ff[29:0], 2'h0};
            norm_z = zc_ff + 5'd2;
         end
         default: if (!x_ff[31]) begin
            norm_x = {x_ff[30:0], 1'b0};
            norm_z = zc_ff + 5'd1;
         end
      endcase
   end

   assign square   = y_ff * y_ff;
   assign sq_top   = square[61:30];
   assign msb_pos  = 5'd31 - zc_ff;
   assign exp_off  = $signed({1'b0, msb_pos}) - 6'sd16;
   assign log2_val = $signed({exp_off, frac_ff});
   assign rnd_sum  = prod_ff + lec_pkg::LOG_ROUND;
   assign log_value = lec_pkg::LOG_W'($signed(rnd_sum[55:34]));

   always_comb begin
      state_in = state_ff;
      idle = 1'b0;
      done = 1'b0;
      unique case (state_ff)
         lec_pkg::LOG_IDLE: begin
            idle = 1'b1;
            if (start) state_in = lec_pkg::LOG_NORM;
         end
         lec_pkg::LOG_NORM: begin
            if (cnt_ff == CNT_W'(lec_pkg::NORM_STEPS - 1)) state_in = lec_pkg::LOG_SQUARE;
         end
         lec_pkg::LOG_SQUARE: begin
            if (cnt_ff == CNT_W'(lec_pkg::LOG_FRAC_BITS - 1)) state_in = lec_pkg::LOG_SCALE;
         end
         lec_pkg::LOG_SCALE: begin
            state_in = lec_pkg::LOG_DONE;
         end
         lec_pkg::LOG_DONE: begin
            done = 1'b1;
            state_in = lec_pkg::LOG_IDLE;
         end
         default: state_in = lec_pkg::LOG_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lec_pkg::LOG_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         lec_pkg::LOG_IDLE: begin
            if (start) begin
               // zero energy counts as one LSB
               x_ff  <= (energy == '0) ? lec_pkg::ENERGY_W'(1) : energy;
               zc_ff <= '0;
            end
         end
         lec_pkg::LOG_NORM: begin
            x_ff  <= norm_x;
            zc_ff <= norm_z;
            y_ff  <= norm_x[31:1];
         end
         lec_pkg::LOG_SQUARE: begin
            if (sq_top[31]) begin
               y_ff    <= sq_top[31:1];
               frac_ff <= {frac_ff[lec_pkg::LOG_FRAC_BITS-2:0], 1'b1};
            end else begin
               y_ff    <= sq_top[30:0];
               frac_ff <= {frac_ff[lec_pkg::LOG_FRAC_BITS-2:0], 1'b0};
            end
         end
         lec_pkg::LOG_SCALE: begin
            prod_ff <= log2_val * $signed(lec_pkg::LOG10_2_Q30);
         end
         default: ;
      endcase
   end

endmodule

FILE: src/lec_cell.sv
module lec_cell (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic signed [lec_pkg::LOG_W-1:0]  d_in,
   output logic signed [lec_pkg::LOG_W-1:0]  q_out
);

   logic signed [lec_pkg::LOG_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (shift_en) value_ff <= d_in;
   end

   assign q_out = value_ff;

endmodule

FILE: src/lec_mac.sv
module lec_mac #(
   parameter int NUM_BANDS = 24,
   parameter int ACC_W     = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lec_pkg::mac_ctrl_type             ctrl,
   input  logic signed [lec_pkg::LOG_W-1:0]  log_head,
   output logic                              done,
   output logic signed [ACC_W-1:0]           acc
);

   localparam int PHASE_MOD = 4 * NUM_BANDS;
   localparam int PHASE_W   = $clog2(PHASE_MOD);
   localparam int U_W       = $clog2(NUM_BANDS + 1);
   localparam int PROD_W    = lec_pkg::LOG_W + lec_pkg::COS_W;

   logic [lec_pkg::SIN_W-1:0] sin_rom [NUM_BANDS+1];

   for (genvar g = 0; g <= NUM_BANDS; g++) begin : g_sin
      localparam longint Angle = ((longint'(g) <<< 30) + NUM_BANDS / 2) / NUM_BANDS;
      localparam logic [lec_pkg::SIN_W-1:0] Sine = lec_pkg::sin_quarter(Angle);
      assign sin_rom[g] = Sine;
   end

   logic [PHASE_W-1:0] base_ff, step_ff, m_ff;
   logic [PHASE_W:0]   base_sum, step_sum, m_sum;
   logic [PHASE_W-1:0] base_in, step_in, m_cur, m_next, rem_full;
   logic [1:0]         quad;
   logic [U_W-1:0]     u_idx;
   logic [lec_pkg::SIN_W-1:0] sin_val;
   logic signed [lec_pkg::COS_W-1:0] cos_val;

   logic signed [lec_pkg::COS_W-1:0] cos_ff;
   logic signed [lec_pkg::LOG_W-1:0] log_ff;
   logic                      v1_ff, first1_ff, last1_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_rnd;
   logic                      v2_ff, first2_ff, last2_ff;
   logic signed [ACC_W-1:0]   acc_ff, term;
   logic                      done_ff;

   // phase (j+1)(2i+1) mod 4N stepped by 2(j+1) along the bands
   always_comb begin
      base_sum = {1'b0, base_ff} + (PHASE_W+1)'(1);
      base_in  = (base_sum >= (PHASE_W+1)'(PHASE_MOD)) ?
                 PHASE_W'(base_sum - (PHASE_W+1)'(PHASE_MOD)) : PHASE_W'(base_sum);
      step_sum = {1'b0, step_ff} + (PHASE_W+1)'(2);
      step_in  = (step_sum >= (PHASE_W+1)'(PHASE_MOD)) ?
                 PHASE_W'(step_sum - (PHASE_W+1)'(PHASE_MOD)) : PHASE_W'(step_sum);
      m_cur    = ctrl.first ? base_ff : m_ff;
      m_sum    = {1'b0, m_cur} + {1'b0, step_ff};
      m_next   = (m_sum >= (PHASE_W+1)'(PHASE_MOD)) ?
                 PHASE_W'(m_sum - (PHASE_W+1)'(PHASE_MOD)) : PHASE_W'(m_sum);
   end

   // quadrant and mirrored index into the quarter-wave sine table
   always_comb begin
      if (m_cur >= PHASE_W'(3 * NUM_BANDS)) begin
         quad     = 2'd3;
         rem_full = m_cur - PHASE_W'(3 * NUM_BANDS);
      end else if (m_cur >= PHASE_W'(2 * NUM_BANDS)) begin
         quad     = 2'd2;
         rem_full = m_cur - PHASE_W'(2 * NUM_BANDS);
      end else if (m_cur >= PHASE_W'(NUM_BANDS)) begin
         quad     = 2'd1;
         rem_full = m_cur - PHASE_W'(NUM_BANDS);
      end else begin
         quad     = 2'd0;
         rem_full = m_cur;
      end
      u_idx   = quad[0] ? U_W'(rem_full) : U_W'(NUM_BANDS) - U_W'(rem_full);
      sin_val = sin_rom[u_idx];
      cos_val = (quad[1] ^ quad[0]) ? -$signed({1'b0, sin_val}) : $signed({1'b0, sin_val});
   end

   assign prod_rnd = prod_ff + PROD_W'(lec_pkg::TERM_ROUND);
   assign term     = ACC_W'($signed(prod_rnd[PROD_W-1:lec_pkg::SIN_FRAC]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
         base_ff <= PHASE_W'(1);
         step_ff <= PHASE_W'(2);
      end else begin
         v1_ff   <= ctrl.issue;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff && last2_ff;
         if (ctrl.frame_start) begin
            base_ff <= PHASE_W'(1);
            step_ff <= PHASE_W'(2);
         end else if (ctrl.next_coeff) begin
            base_ff <= base_in;
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) m_ff <= m_next;
      cos_ff    <= cos_val;
      log_ff    <= log_head;
      first1_ff <= ctrl.first;
      last1_ff  <= ctrl.last;
      prod_ff   <= log_ff * cos_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      if (v2_ff) acc_ff <= first2_ff ? term : acc_ff + term;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

FILE: src/log_energy_cepstrum_core.sv
// Channel  Direction  Ports                                         Moves
// req      in         req_valid/req_ready, req_band_energy          one band energy request
// rsp      out        rsp_valid/rsp_ready, rsp_coefficient,         one cepstral coefficient
//                     rsp_coeff_index, rsp_last_coeff
//
// A band request holds the log unit through normalization, squaring per fraction bit,
// scale and round; the next request is taken in the cycle after the log lands in the ring.
// After the last band of a frame the single MAC walks the ring once per coefficient;
// no request is taken meanwhile. A held result with rsp_ready low stalls the sequencer
// before it loads the next coefficient. Synchronous reset clears control; ring contents
// stay undefined until a frame has been loaded.
module log_energy_cepstrum_core #(
   parameter int NUM_BANDS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lec_pkg::ENERGY_W-1:0]          req_band_energy,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lec_pkg::COEF_W-1:0]     rsp_coefficient,
   output logic [lec_pkg::CIDX_W-1:0]            rsp_coeff_index,
   output logic                                  rsp_last_coeff
);

   localparam int BAND_W = $clog2(NUM_BANDS);
   localparam int ACC_W  = 21 + BAND_W;

   lec_pkg::seq_state_type seq_state_ff, seq_state_in;
   lec_pkg::mac_ctrl_type  mac_ctrl;

   logic [BAND_W-1:0]          band_cnt_ff, issue_cnt_ff;
   logic [lec_pkg::CIDX_W-1:0] coeff_ff;

   logic                       log_start, log_idle, log_done;
   logic signed [lec_pkg::LOG_W-1:0] log_value;
   logic                       frame_done, rotate, ring_shift;
   logic                       issue_last, coeff_last, rsp_load;
   logic                       mac_done;
   logic signed [ACC_W-1:0]    mac_acc;
   logic signed [31:0]         acc_wide;
   logic signed [lec_pkg::COEF_W-1:0] sat_coef;

   logic                       rsp_valid_ff;
   logic signed [lec_pkg::COEF_W-1:0] rsp_coefficient_ff;
   logic [lec_pkg::CIDX_W-1:0] rsp_coeff_index_ff;
   logic                       rsp_last_coeff_ff;

   logic signed [lec_pkg::LOG_W-1:0] cell_q [NUM_BANDS];

   lec_log_unit u_log (
      .clock     (clock),
      .reset     (reset),
      .start     (log_start),
      .energy    (req_band_energy),
      .idle      (log_idle),
      .done      (log_done),
      .log_value (log_value)
   );

   // new logs enter at the tail; during a coefficient pass the head wraps to the tail
   for (genvar k = 0; k < NUM_BANDS; k++) begin : g_ring
      logic signed [lec_pkg::LOG_W-1:0] feed;
      if (k == NUM_BANDS - 1) begin : g_tail
         assign feed = rotate ? cell_q[0] : log_value;
      end else begin : g_body
         assign feed = cell_q[k+1];
      end
      lec_cell u_cell (
         .clock    (clock),
         .shift_en (ring_shift),
         .d_in     (feed),
         .q_out    (cell_q[k])
      );
   end

   lec_mac #(
      .NUM_BANDS (NUM_BANDS),
      .ACC_W     (ACC_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .log_head (cell_q[0]),
      .done     (mac_done),
      .acc      (mac_acc)
   );

   assign req_ready  = log_idle && (seq_state_ff == lec_pkg::SEQ_IDLE);
   assign log_start  = req_valid && req_ready;
   assign frame_done = log_done && (band_cnt_ff == BAND_W'(NUM_BANDS - 1));
   assign rotate     = (seq_state_ff == lec_pkg::SEQ_RUN);
   assign ring_shift = rotate || log_done;
   assign issue_last = (issue_cnt_ff == BAND_W'(NUM_BANDS - 1));
   assign coeff_last = (coeff_ff == lec_pkg::CIDX_W'(lec_pkg::NUM_COEFFS - 1));
   assign rsp_load   = (seq_state_ff == lec_pkg::SEQ_WRITE) && (!rsp_valid_ff || rsp_ready);

   assign mac_ctrl.frame_start = frame_done;
   assign mac_ctrl.next_coeff  = rsp_load && !coeff_last;
   assign mac_ctrl.issue       = rotate;
   assign mac_ctrl.first       = rotate && (issue_cnt_ff == '0);
   assign mac_ctrl.last        = rotate && issue_last;

   always_comb begin
      seq_state_in = seq_state_ff;
      unique case (seq_state_ff)
         lec_pkg::SEQ_IDLE:  if (frame_done) seq_state_in = lec_pkg::SEQ_RUN;
         lec_pkg::SEQ_RUN:   if (issue_last) seq_state_in = lec_pkg::SEQ_WAIT;
         lec_pkg::SEQ_WAIT:  if (mac_done) seq_state_in = lec_pkg::SEQ_WRITE;
         lec_pkg::SEQ_WRITE: begin
            if (rsp_load) seq_state_in = coeff_last ? lec_pkg::SEQ_IDLE : lec_pkg::SEQ_RUN;
         end
         default: seq_state_in = lec_pkg::SEQ_IDLE;
      endcase
   end

   // clamp the sum to the signed Q8.16 range
   always_comb begin
      acc_wide = 32'(mac_acc);
      if (acc_wide > lec_pkg::COEF_MAX) begin
         sat_coef = lec_pkg::COEF_W'(lec_pkg::COEF_MAX);
      end else if (acc_wide < lec_pkg::COEF_MIN) begin
         sat_coef = lec_pkg::COEF_W'(lec_pkg::COEF_MIN);
      end else begin
         sat_coef = acc_wide[lec_pkg::COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= lec_pkg::SEQ_IDLE;
         band_cnt_ff  <= '0;
         issue_cnt_ff <= '0;
         coeff_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_state_ff <= seq_state_in;
         if (log_done) band_cnt_ff <= frame_done ? '0 : band_cnt_ff + BAND_W'(1);
         if (rotate) issue_cnt_ff <= issue_last ? '0 : issue_cnt_ff + BAND_W'(1);
         if (frame_done) begin
            coeff_ff <= '0;
         end else if (mac_ctrl.next_coeff) begin
            coeff_ff <= coeff_ff + lec_pkg::CIDX_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_coefficient_ff <= sat_coef;
         rsp_coeff_index_ff <= coeff_ff;
         rsp_last_coeff_ff  <= coeff_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_coeff_index = rsp_coeff_index_ff;
   assign rsp_last_coeff  = rsp_last_coeff_ff;

   a_no_insert_during_pass: assert property (@(posedge clock) disable iff (reset)
      !(log_done && rotate))
      else $error("log result arrived while the ring was rotating");

   a_mac_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (seq_state_ff == lec_pkg::SEQ_WAIT))
      else $error("MAC finished outside the wait state");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (seq_state_ff == lec_pkg::SEQ_RUN) && (coeff_ff == '0)
                     && (issue_cnt_ff == '0))
      else $error("coefficient pass did not start cleanly after a full frame");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && coeff_last) |-> (band_cnt_ff == '0))
      else $error("band count not cleared at the end of a frame");

endmodule
